[sv/imhq_pkg.sv]
// Package of the indexed min-heap queue: item codes, status codes and field widths.
// Depends on nothing; used by indexed_min_heap_queue.
`default_nettype none
package imhq_pkg;

   localparam int ActionWidth = 2;
   localparam int NodeWidth   = 10;
   localparam int KeyWidth    = 16;
   localparam int StatusWidth = 2;
   localparam int CountWidth  = 9;

   typedef enum logic [ActionWidth-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [StatusWidth-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_PRESENT   = 2'd3
   } status_type;

   // One heap slot as stored: node id in the upper bits, key in the lower bits.
   typedef struct packed {
      logic [NodeWidth-1:0] node;
      logic [KeyWidth-1:0]  key;
   } entry_type;

endpackage
`default_nettype wire

[sv/imhq_ram.sv]
// Simple dual-port RAM of the indexed min-heap queue: one write and one registered read.
// Depends on nothing.
`default_nettype none
module imhq_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 256
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

[sv/indexed_min_heap_queue.sv]
// Top level of the indexed min-heap queue: sequencer, heap slot RAM and node map RAM.
// Depends on imhq_pkg and imhq_ram.
`default_nettype none
// Binary min-heap of node ids ordered by 16-bit key, with a map from node id to heap
// slot so that any node can be removed by id (popping the minimum is removing the top
// node). Each request word is an insert, a remove, a clear or a no-op, and each yields
// exactly one response word with a status, the top node and key, and the count. One
// sequencer walks the heap through a single read port of the slot RAM: a sift moves one
// level per parent read and compare going up, and per read of the left child, a read of
// the right child where there is one, and a compare going down. A clear, and the state
// after reset, zero the node map one entry a cycle, and no request is taken while they
// do. The next request is taken while a finished response still waits in the output
// register.
module indexed_min_heap_queue #(
   parameter int CAPACITY = 256,
   parameter int NODES    = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [9:0] node_id, [25:10] key, rest zero
   input  wire logic [1:0]  req_tuser,   // [1:0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [1:0] status, [2] top_valid, [12:3] top_node,
                                         // [28:13] top_key, [37:29] count, rest zero
);
   // Slot positions are 1-based and may reach CAPACITY itself.
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int SW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
   localparam int NW = NODES > 1 ? $clog2(NODES) : 1;
   localparam int EW = imhq_pkg::NodeWidth + imhq_pkg::KeyWidth;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_MAP, ST_LAST, ST_UP_RD, ST_UP_CMP,
      ST_DN_RD, ST_DN_L, ST_DN_R, ST_DN_CMP, ST_DONE
   } state_type;

   state_type                         state_ff, state_in;
   imhq_pkg::action_type              act_ff, act_in;
   imhq_pkg::status_type              status_ff, status_in;
   imhq_pkg::entry_type               x_ff, x_in;        // the entry being moved
   imhq_pkg::entry_type               left_ff, left_in;  // left child during sift down
   imhq_pkg::entry_type               ch_ff, ch_in;      // chosen child
   imhq_pkg::entry_type               top_ff, top_in;
   logic [imhq_pkg::NodeWidth-1:0]    node_ff, node_in;
   logic [PW-1:0]                     p_ff, p_in;
   logic [PW:0]                       c_ff, c_in;
   logic [PW-1:0]                     fill_ff, fill_in;
   logic                              removing_ff, removing_in;
   logic                              moved_ff, moved_in;
   logic                              clr_req_ff, clr_req_in;
   logic [NW-1:0]                     cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [39:0]                       rsp_data_ff, rsp_data_in;

   // Slot RAM and node map RAM ports.
   logic              slot_we;
   logic [SW-1:0]     slot_wa, slot_ra;
   logic [EW-1:0]     slot_wd, slot_rd_raw;
   imhq_pkg::entry_type slot_rd;
   logic              map_we;
   logic [NW-1:0]     map_wa, map_ra;
   logic [PW-1:0]     map_wd, map_rd;

   logic [31:0] req_node32, node32, fill32;
   logic        req_in_range;
   logic [PW:0] c2;

   assign slot_rd    = imhq_pkg::entry_type'(slot_rd_raw);
   assign req_node32 = 32'(req_tdata[imhq_pkg::NodeWidth-1:0]);
   assign node32     = 32'(node_ff);
   assign fill32     = 32'(fill_ff);
   assign req_in_range = req_node32 < 32'(NODES);
   assign c2         = {p_ff, 1'b0};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_wa),
      .wr_data(slot_wd),
      .rd_addr(slot_ra),
      .rd_data(slot_rd_raw)
   );

   imhq_ram #(.WIDTH(PW), .DEPTH(NODES)) u_map_ram (
      .clock  (clock),
      .wr_en  (map_we),
      .wr_addr(map_wa),
      .wr_data(map_wd),
      .rd_addr(map_ra),
      .rd_data(map_rd)
   );

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      status_in   = status_ff;
      x_in        = x_ff;
      left_in     = left_ff;
      ch_in       = ch_ff;
      top_in      = top_ff;
      node_in     = node_ff;
      p_in        = p_ff;
      c_in        = c_ff;
      fill_in     = fill_ff;
      removing_in = removing_ff;
      moved_in    = moved_ff;
      clr_req_in  = clr_req_ff;
      cnt_in      = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      slot_we     = 1'b0;
      slot_wa     = SW'(p_ff - PW'(1));
      slot_wd     = x_ff;
      slot_ra     = SW'(p_ff - PW'(1));
      map_we      = 1'b0;
      map_wa      = node32[NW-1:0];
      map_wd      = p_ff;
      map_ra      = req_node32[NW-1:0];

      unique case (state_ff)
         ST_CLR: begin
            // Zero one node map entry per cycle.
            map_we = 1'b1;
            map_wa = cnt_ff;
            map_wd = '0;
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(NODES - 1)) begin
               cnt_in = '0;
               if (clr_req_ff) begin
                  fill_in   = '0;
                  status_in = imhq_pkg::STAT_OK;
                  state_in  = ST_DONE;
               end else begin
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in      = imhq_pkg::action_type'(req_tuser);
               node_in     = req_tdata[imhq_pkg::NodeWidth-1:0];
               x_in.node   = req_tdata[imhq_pkg::NodeWidth-1:0];
               x_in.key    = req_tdata[imhq_pkg::NodeWidth +: imhq_pkg::KeyWidth];
               moved_in    = 1'b0;
               removing_in = 1'b0;
               status_in   = imhq_pkg::STAT_OK;
               unique case (imhq_pkg::action_type'(req_tuser))
                  imhq_pkg::ACT_CLEAR: begin
                     clr_req_in = 1'b1;
                     cnt_in     = '0;
                     state_in   = ST_CLR;
                  end
                  imhq_pkg::ACT_NOP: state_in = ST_DONE;
                  default: begin
                     if (req_in_range) begin
                        state_in = ST_MAP;
                     end else begin
                        status_in = imhq_pkg::STAT_NOT_FOUND;
                        state_in  = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_MAP: begin
            if (act_ff == imhq_pkg::ACT_INSERT) begin
               if (map_rd != '0) begin
                  status_in = imhq_pkg::STAT_PRESENT;
                  state_in  = ST_DONE;
               end else if (fill32 >= 32'(CAPACITY)) begin
                  status_in = imhq_pkg::STAT_FULL;
                  state_in  = ST_DONE;
               end else begin
                  fill_in  = fill_ff + PW'(1);
                  p_in     = fill_ff + PW'(1);
                  state_in = ST_UP_RD;
               end
            end else if (map_rd == '0) begin
               status_in = imhq_pkg::STAT_NOT_FOUND;
               state_in  = ST_DONE;
            end else begin
               // Mark the node absent and fetch the last entry to fill its slot.
               map_we      = 1'b1;
               map_wd      = '0;
               fill_in     = fill_ff - PW'(1);
               p_in        = map_rd;
               removing_in = 1'b1;
               slot_ra     = SW'(fill_ff - PW'(1));
               state_in    = (map_rd == fill_ff) ? ST_DONE : ST_LAST;
            end
         end
         ST_LAST: begin
            x_in     = slot_rd;
            state_in = ST_UP_RD;
         end
         ST_UP_RD: begin
            if (p_ff == PW'(1)) begin
               if (removing_ff && !moved_ff) begin
                  state_in = ST_DN_RD;
               end else begin
                  slot_we  = 1'b1;
                  map_we   = 1'b1;
                  map_wa   = NW'(x_ff.node);
                  state_in = ST_DONE;
               end
            end else begin
               slot_ra  = SW'((p_ff >> 1) - PW'(1));
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (x_ff.key < slot_rd.key) begin
               // Parent moves down into the hole.
               slot_we  = 1'b1;
               slot_wd  = slot_rd;
               map_we   = 1'b1;
               map_wa   = NW'(slot_rd.node);
               p_in     = p_ff >> 1;
               moved_in = 1'b1;
               state_in = ST_UP_RD;
            end else if (removing_ff && !moved_ff) begin
               state_in = ST_DN_RD;
            end else begin
               slot_we  = 1'b1;
               map_we   = 1'b1;
               map_wa   = NW'(x_ff.node);
               state_in = ST_DONE;
            end
         end
         ST_DN_RD: begin
            if (c2 > {1'b0, fill_ff}) begin
               slot_we  = 1'b1;
               map_we   = 1'b1;
               map_wa   = NW'(x_ff.node);
               state_in = ST_DONE;
            end else begin
               c_in     = c2;
               slot_ra  = SW'(c2 - (PW+1)'(1));
               state_in = ST_DN_L;
            end
         end
         ST_DN_L: begin
            left_in = slot_rd;
            ch_in   = slot_rd;
            if (c_ff < {1'b0, fill_ff}) begin
               slot_ra  = SW'(c_ff);
               state_in = ST_DN_R;
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_R: begin
            // The left child wins ties.
            if (left_ff.key > slot_rd.key) begin
               ch_in = slot_rd;
               c_in  = c_ff + (PW+1)'(1);
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (x_ff.key > ch_ff.key) begin
               slot_we  = 1'b1;
               slot_wd  = ch_ff;
               map_we   = 1'b1;
               map_wa   = NW'(ch_ff.node);
               p_in     = PW'(c_ff);
               state_in = ST_DN_RD;
            end else begin
               slot_we  = 1'b1;
               map_we   = 1'b1;
               map_wa   = NW'(x_ff.node);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            clr_req_in = 1'b0;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[1:0] = status_ff;
               if (fill_ff != '0) begin
                  rsp_data_in[2]     = 1'b1;
                  rsp_data_in[12:3]  = top_ff.node;
                  rsp_data_in[28:13] = top_ff.key;
               end
               rsp_data_in[37:29] = fill32[imhq_pkg::CountWidth-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Keep a copy of the top slot so the response needs no extra read.
      if (slot_we && slot_wa == '0) begin
         top_in = imhq_pkg::entry_type'(slot_wd);
      end
      // Map entries hold the 1-based slot of the entry being written.
      if (map_we && map_wd != '0 && slot_we) begin
         map_wd = p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         clr_req_ff   <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         removing_ff  <= 1'b0;
         moved_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_req_ff   <= clr_req_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         removing_ff  <= removing_in;
         moved_ff     <= moved_in;
      end
      act_ff      <= act_in;
      status_ff   <= status_in;
      x_ff        <= x_in;
      left_ff     <= left_in;
      ch_ff       <= ch_in;
      top_ff      <= top_in;
      node_ff     <= node_in;
      p_ff        <= p_in;
      c_ff        <= c_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire

[sv/imhq_checker.sv]
// Port-level checker of the indexed min-heap queue and its bind to the top level.
// Depends on indexed_min_heap_queue.
`default_nettype none
module imhq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   // The node map is swept after reset, so no request is taken right away.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");

   // A taken request keeps the block busy, so requests are never taken back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // An empty heap shows no top, a nonempty one does.
   a_top_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[37:29] == 9'd0) == !rsp_tdata[2]))
      else $error("top_valid disagrees with count");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");
endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire
